### sv/pabb_pkg.sv
// -----------------------------------------------------------------------------
// pabb_pkg
// Shared types, codes and helpers for the pixel alpha blit blender.
// -----------------------------------------------------------------------------
package pabb_pkg;

  localparam int unsigned PaletteEntriesDefault = 256;
  localparam int unsigned ByteW                 = 8;
  localparam int unsigned ColorW                = 24;
  localparam int unsigned InDataW               = 96;
  localparam int unsigned OutDataW              = 32;
  localparam int unsigned FmtW                  = 2;
  localparam int unsigned ProdW                 = 16;

  typedef enum logic [FmtW-1:0] {
    FMT_BLEND   = 2'd0,
    FMT_COPY    = 2'd1,
    FMT_INDEXED = 2'd2,
    FMT_PASS    = 2'd3
  } fmt_e;

  typedef enum logic {
    OP_BLEND     = 1'b0,
    OP_PAL_WRITE = 1'b1
  } op_e;

  typedef logic [ByteW-1:0] byte_t;

  // Pixel request as it leaves the input stage.
  typedef struct packed {
    byte_t src0;
    byte_t src1;
    byte_t src2;
    byte_t src3;
    byte_t tgt_a;
    byte_t tgt_r;
    byte_t tgt_g;
    byte_t tgt_b;
    logic  pal_miss;  // index lies beyond the palette: read as black
  } pix_t;

  // Exact floor(x / 255) for x <= 255 * 255.
  function automatic byte_t div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    t = {1'b0, x} + {{(ProdW-ByteW+1){1'b0}}, x[ProdW-1:ByteW]} + {{ProdW{1'b0}}, 1'b1};
    return t[ProdW-1:ByteW];
  endfunction

endpackage

### sv/pabb_ram.sv
// -----------------------------------------------------------------------------
// pabb_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module pabb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/pabb_mix.sv
// -----------------------------------------------------------------------------
// pabb_mix
// Channel mixing and format selection, then the output register.
// -----------------------------------------------------------------------------
module pabb_mix (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   pix_valid_i,
  input  pabb_pkg::pix_t         pix_i,
  input  logic [pabb_pkg::ColorW-1:0] pal_color_i,
  input  pabb_pkg::fmt_e         fmt_i,
  output logic                   out_valid_o,
  output logic [pabb_pkg::OutDataW-1:0] out_data_o
);
  import pabb_pkg::*;

  logic                   s2_valid_q;
  logic                   s2_blend_q;
  logic [ProdW-1:0]       prod_r_q, prod_g_q, prod_b_q;
  logic [ProdW-1:0]       prod_r_d, prod_g_d, prod_b_d;
  byte_t                  res_a_q, res_1_q, res_2_q, res_3_q;
  byte_t                  res_a_d, res_1_d, res_2_d, res_3_d;
  logic [ColorW-1:0]      entry;
  logic [ByteW:0]         alpha_sum;
  byte_t                  inv_a;
  logic                   out_valid_q;
  logic [OutDataW-1:0]    out_data_q;

  assign inv_a = ~pix_i.src0;  // 255 - a
  assign entry = pix_i.pal_miss ? '0 : pal_color_i;
  assign alpha_sum = {1'b0, pix_i.tgt_a} + {1'b0, pix_i.src0};

  always_comb begin
    prod_r_d = {{ByteW{1'b0}}, inv_a} * {{ByteW{1'b0}}, pix_i.tgt_r}
             + {{ByteW{1'b0}}, pix_i.src0} * {{ByteW{1'b0}}, pix_i.src1};
    prod_g_d = {{ByteW{1'b0}}, inv_a} * {{ByteW{1'b0}}, pix_i.tgt_g}
             + {{ByteW{1'b0}}, pix_i.src0} * {{ByteW{1'b0}}, pix_i.src2};
    prod_b_d = {{ByteW{1'b0}}, inv_a} * {{ByteW{1'b0}}, pix_i.tgt_b}
             + {{ByteW{1'b0}}, pix_i.src0} * {{ByteW{1'b0}}, pix_i.src3};
  end

  always_comb begin
    unique case (fmt_i)
      FMT_BLEND: begin
        res_a_d = alpha_sum[ByteW] ? '1 : alpha_sum[ByteW-1:0];
        res_1_d = '0;
        res_2_d = '0;
        res_3_d = '0;
      end
      FMT_COPY: begin
        res_a_d = '1;
        res_1_d = pix_i.src0;
        res_2_d = pix_i.src1;
        res_3_d = pix_i.src2;
      end
      FMT_INDEXED: begin
        // palette holds red high, blue low; emit blue, green, red
        res_a_d = '1;
        res_1_d = entry[ByteW-1:0];
        res_2_d = entry[2*ByteW-1:ByteW];
        res_3_d = entry[3*ByteW-1:2*ByteW];
      end
      default: begin
        res_a_d = pix_i.tgt_a;
        res_1_d = pix_i.tgt_r;
        res_2_d = pix_i.tgt_g;
        res_3_d = pix_i.tgt_b;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q  <= pix_valid_i;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && pix_valid_i) begin
      s2_blend_q <= (fmt_i == FMT_BLEND);
      prod_r_q   <= prod_r_d;
      prod_g_q   <= prod_g_d;
      prod_b_q   <= prod_b_d;
      res_a_q    <= res_a_d;
      res_1_q    <= res_1_d;
      res_2_q    <= res_2_d;
      res_3_q    <= res_3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s2_valid_q) begin
      if (s2_blend_q) begin
        out_data_q <= {div255(prod_b_q), div255(prod_g_q), div255(prod_r_q), res_a_q};
      end else begin
        out_data_q <= {res_3_q, res_2_q, res_1_q, res_a_q};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sv/pixel_alpha_blit_blender.sv
// -----------------------------------------------------------------------------
// pixel_alpha_blit_blender
// Blends, copies or palette-maps one source pixel onto one target pixel, or passes
// the target pixel through.
// Pipeline: a pixel request passes the palette read register, then the channel
//   product register, then the divide into the output register on the master side.
// Throughput: one request per cycle; the pipeline holds only while the output
//   register keeps a result that the master side has not taken.
// Reset: asynchronous, active low; clears the pipeline and sets the format to
//   blend. Palette contents are undefined until written.
module pixel_alpha_blit_blender #(
  parameter int unsigned PALETTE_ENTRIES = pabb_pkg::PaletteEntriesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: source format
  input  logic                            cfg_we_i,
  input  logic [pabb_pkg::FmtW-1:0]       cfg_wdata_i,
  // slave side
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: src_byte0, src_byte1, src_byte2, src_byte3, tgt_alpha, tgt_red,
  //        tgt_green, tgt_blue, palette_index, palette_color (lowest first)
  input  logic [pabb_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: operation
  input  logic                            s_axis_tuser,
  // master side
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: out_alpha, out_byte1, out_byte2, out_byte3 (lowest first)
  output logic [pabb_pkg::OutDataW-1:0]   m_axis_tdata
);
  import pabb_pkg::*;

  localparam int unsigned IdxW = $clog2(PALETTE_ENTRIES);

  fmt_e                fmt_q;
  logic                adv;
  logic                accept;
  op_e                 op;
  pix_t                pix_d;
  pix_t                pix_q;
  logic                pix_valid_q;
  byte_t               pal_idx;
  logic [ColorW-1:0]   pal_col;
  logic                wr_in_range;
  logic                rd_in_range;
  logic                pal_we;
  logic                pal_re;
  logic [ColorW-1:0]   pal_rdata;
  logic                out_valid;

  // advance the whole pipeline whenever the output register is free or drains
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign op            = op_e'(s_axis_tuser);

  assign pix_d.src0  = s_axis_tdata[7:0];
  assign pix_d.src1  = s_axis_tdata[15:8];
  assign pix_d.src2  = s_axis_tdata[23:16];
  assign pix_d.src3  = s_axis_tdata[31:24];
  assign pix_d.tgt_a = s_axis_tdata[39:32];
  assign pix_d.tgt_r = s_axis_tdata[47:40];
  assign pix_d.tgt_g = s_axis_tdata[55:48];
  assign pix_d.tgt_b = s_axis_tdata[63:56];
  assign pal_idx     = s_axis_tdata[71:64];
  assign pal_col     = s_axis_tdata[95:72];

  assign wr_in_range = {1'b0, pal_idx} < (ByteW+1)'(PALETTE_ENTRIES);
  assign rd_in_range = {1'b0, pix_d.src0} < (ByteW+1)'(PALETTE_ENTRIES);
  assign pix_d.pal_miss = !rd_in_range;

  // one palette access per request, so an in-range write always lands before a later read
  assign pal_we = accept && (op == OP_PAL_WRITE) && wr_in_range;
  assign pal_re = accept && (op == OP_BLEND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_BLEND;
    end else if (cfg_we_i) begin
      fmt_q <= fmt_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (adv) begin
      pix_valid_q <= pal_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_re) begin
      pix_q <= pix_d;
    end
  end

  pabb_ram #(
    .Width (ColorW),
    .Depth (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (pal_we),
    .wr_addr_i (pal_idx[IdxW-1:0]),
    .wr_data_i (pal_col),
    .rd_en_i   (pal_re),
    .rd_addr_i (pix_d.src0[IdxW-1:0]),
    .rd_data_o (pal_rdata)
  );

  pabb_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .pix_valid_i (pix_valid_q),
    .pix_i       (pix_q),
    .pal_color_i (pal_rdata),
    .fmt_i       (fmt_q),
    .out_valid_o (out_valid),
    .out_data_o  (m_axis_tdata)
  );

  assign m_axis_tvalid = out_valid;

endmodule

### sv/pabb_checker.sv
// -----------------------------------------------------------------------------
// pabb_checker
// Port-level checks for the pixel alpha blit blender, bound to the top level.
// -----------------------------------------------------------------------------
module pabb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pabb_pkg::OutDataW-1:0] m_axis_tdata
);

  // a stalled result holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no result can come out straight after reset is released
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid ##1 !m_axis_tvalid)
    else $error("result too soon after reset");

  // an empty output register never blocks a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request blocked with empty output");

  // a result being taken frees room for the next request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("request blocked while output drains");

endmodule

bind pixel_alpha_blit_blender pabb_checker u_pabb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
